// ===== sv/uss_pkg.sv =====
`timescale 1ns / 1ps
package uss_pkg;

  // configuration register indexes
  localparam logic CFG_SAMPLES_PER_FRAME = 1'b0;
  localparam logic CFG_STEP_SCALE        = 1'b1;

  // register reset values
  localparam logic [6:0]  SPF_RESET  = 7'd10;
  localparam logic [23:0] STEP_RESET = 24'd178957;

  // sine polynomial coefficients
  localparam logic [15:0] COEF_A = 16'd51466;
  localparam logic [14:0] COEF_B = 15'd21077;
  localparam logic [11:0] COEF_C = 12'd2383;

  localparam logic [16:0] SINE_MAX = 17'd32767;

  // one sample request from the frame sequencer to the sine pipeline
  typedef struct packed {
    logic [31:0] phase;
    logic        voiced;
    logic        last;
    logic        eos;
  } tok_t;

  // side information carried along the sine pipeline
  typedef struct packed {
    logic voiced;
    logic neg;
    logic last;
    logic eos;
  } flags_t;

endpackage

// ===== sv/uss_pitch_if.sv =====
`timescale 1ns / 1ps
interface uss_pitch_if;
  logic        valid;
  logic        ready;
  logic [15:0] pitch_hz;
  logic        final_frame;

  modport source (output valid, pitch_hz, final_frame, input ready);
  modport sink (input valid, pitch_hz, final_frame, output ready);
endinterface

// ===== sv/uss_sample_if.sv =====
`timescale 1ns / 1ps
interface uss_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_of_frame;
  logic               end_of_signal;

  modport source (output valid, sample, last_of_frame, end_of_signal, input ready);
  modport sink (input valid, sample, last_of_frame, end_of_signal, output ready);
endinterface

// ===== sv/uss_cfg_if.sv =====
`timescale 1ns / 1ps
interface uss_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/upsampled_sine_source.sv =====
`timescale 1ns / 1ps
// channel  | role   | payload
// cfg      | sink   | index (0 samples_per_frame, 1 step_scale), data[23:0]
// pitch    | sink   | pitch_hz[15:0] Q12.4, final_frame
// samples  | source | sample[15:0] Q1.15, last_of_frame, end_of_signal
//
// one sample leaves per cycle while ready on samples is high, and the next frame's
// first sample follows the previous frame's last without a gap when its request is
// already held. the first sample of a frame passes through the holding register,
// frame load, phase step, three polynomial stages and the output register.
// reset clears the phase and the pipeline and loads 10 samples per frame and
// a step scale of 178957; low ready on a waiting sample freezes the phase step
// and the sine stages, while the holding register and an idle frame slot fill.
module upsampled_sine_source
  import uss_pkg::*;
#(
  parameter int SINE_TABLE_ADDR_BITS  = 10,
  parameter int MAX_SAMPLES_PER_FRAME = 64
) (
  input  logic          clk,
  input  logic          rst,
  uss_cfg_if.sink       cfg,
  uss_pitch_if.sink     pitch,
  uss_sample_if.source  samples
);

  logic [6:0]  spf;
  logic [23:0] step_scale;
  logic        advance;
  logic        tok_valid;
  tok_t        tok;

  // configuration registers
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      spf        <= SPF_RESET;
      step_scale <= STEP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SAMPLES_PER_FRAME: spf        <= cfg.data[6:0];
        CFG_STEP_SCALE:        step_scale <= cfg.data;
        default:               ;
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being drained
  assign advance = !samples.valid || samples.ready;

  uss_frame #(
    .MAX_SAMPLES_PER_FRAME(MAX_SAMPLES_PER_FRAME)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .pitch     (pitch),
    .spf       (spf),
    .step_scale(step_scale),
    .advance   (advance),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  uss_sine #(
    .SINE_TABLE_ADDR_BITS(SINE_TABLE_ADDR_BITS)
  ) u_sine (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .tok_valid(tok_valid),
    .tok      (tok),
    .valid    (samples.valid),
    .sample   (samples.sample),
    .last     (samples.last_of_frame),
    .eos      (samples.end_of_signal)
  );

endmodule

// ===== sv/uss_frame.sv =====
`timescale 1ns / 1ps
module uss_frame
  import uss_pkg::*;
#(
  parameter int MAX_SAMPLES_PER_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst,
  uss_pitch_if.sink   pitch,
  input  logic [6:0]  spf,
  input  logic [23:0] step_scale,
  input  logic        advance,
  output logic        tok_valid,
  output tok_t        tok
);

  localparam int CW = (MAX_SAMPLES_PER_FRAME > 1) ? $clog2(MAX_SAMPLES_PER_FRAME) : 1;

  // request holding register
  logic        hold_valid;
  logic [15:0] hold_pitch;
  logic        hold_final;

  // active frame
  logic          act_valid;
  logic [31:0]   act_inc;
  logic          act_voiced;
  logic          act_final;
  logic [CW-1:0] count;
  logic [CW-1:0] n_last;
  logic [31:0]   phase;

  logic          act_last;
  logic          load;
  logic          emit;
  logic [39:0]   prod;
  logic [39:0]   prod_rnd;
  logic [6:0]    spf_m1;
  logic [CW-1:0] n_last_new;
  logic [31:0]   phase_adv;

  assign act_last = act_valid && (count == n_last);
  assign emit     = advance && act_valid;
  assign load     = hold_valid && (!act_valid || (advance && act_last));
  assign pitch.ready = !rst && (!hold_valid || load);

  // phase increment, rounded Q12.4 times step scale
  assign prod     = 40'(hold_pitch) * 40'(step_scale);
  assign prod_rnd = prod + 40'd8;

  // clamp samples per frame to 1..max
  assign spf_m1 = spf - 7'd1;
  always_comb begin
    if (spf == 7'd0) begin
      n_last_new = '0;
    end else if (spf > 7'(MAX_SAMPLES_PER_FRAME)) begin
      n_last_new = CW'(MAX_SAMPLES_PER_FRAME - 1);
    end else begin
      n_last_new = spf_m1[CW-1:0];
    end
  end

  assign phase_adv = act_voiced ? (phase + act_inc) : phase;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (pitch.valid && pitch.ready) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pitch.valid && pitch.ready) begin
      hold_pitch <= pitch.pitch_hz;
      hold_final <= pitch.final_frame;
    end
  end

  // active frame control
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      count     <= '0;
    end else if (load) begin
      act_valid <= 1'b1;
      count     <= '0;
    end else if (emit) begin
      if (act_last) begin
        act_valid <= 1'b0;
        count     <= '0;
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_inc    <= prod_rnd[35:4];
      act_voiced <= (hold_pitch != 16'd0);
      act_final  <= hold_final;
      n_last     <= n_last_new;
    end
  end

  // phase accumulator, cleared after the last sample of a final frame
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (emit) begin
      phase <= (act_last && act_final) ? 32'd0 : phase_adv;
    end
  end

  // sample request register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (advance) begin
      tok_valid <= act_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tok.phase  <= phase_adv;
      tok.voiced <= act_voiced;
      tok.last   <= act_last;
      tok.eos    <= act_last && act_final;
    end
  end

`ifndef SYNTH
  a_phase_clear: assert property (@(posedge clk) disable iff (rst)
    emit && act_last && act_final |=> phase == 32'd0)
    else $error("phase not cleared after final frame");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> count <= n_last)
    else $error("sample count past end of frame");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> act_valid && count == '0)
    else $error("frame load did not start at sample zero");

  a_hold_keep: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !load |=> hold_valid && $stable(hold_pitch))
    else $error("held frame lost before load");
`endif

endmodule

// ===== sv/uss_sine.sv =====
`timescale 1ns / 1ps
module uss_sine
  import uss_pkg::*;
#(
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               tok_valid,
  input  tok_t               tok,
  output logic               valid,
  output logic signed [15:0] sample,
  output logic               last,
  output logic               eos
);

  localparam int QB = SINE_TABLE_ADDR_BITS - 2;

  logic [SINE_TABLE_ADDR_BITS-1:0] addr;
  logic [1:0]  quad;
  logic [QB:0] r;
  logic [QB:0] x;
  logic [15:0] xn;
  logic [31:0] p1;

  // stage registers
  logic        v1, v2, v3;
  logic [15:0] xn1, xn2, xn3;
  logic [15:0] x21, x22;
  logic [14:0] t12;
  logic [15:0] t23;
  flags_t      f1, f2, f3;

  logic [27:0] p2;
  logic [30:0] p3;
  logic [31:0] p4;
  logic [16:0] y;
  logic [15:0] ys;

  // fold the phase into the first quadrant
  assign addr = tok.phase[31 -: SINE_TABLE_ADDR_BITS];
  assign quad = addr[SINE_TABLE_ADDR_BITS-1 -: 2];
  assign r    = {1'b0, addr[QB-1:0]};
  assign x    = quad[0] ? ((QB+1)'(1 << QB) - r) : r;
  assign xn   = 16'(x) << (15 - QB);
  assign p1   = xn * xn;

  // polynomial products
  assign p2 = 28'(x21) * 28'(COEF_C);
  assign p3 = 31'(x22) * 31'(t12);
  assign p4 = xn3 * t23;
  assign y  = p4[31:15];
  assign ys = (y > SINE_MAX) ? SINE_MAX[15:0] : y[15:0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (advance) begin
      v1    <= tok_valid;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (advance) begin
      xn1       <= xn;
      x21       <= p1[30:15];
      f1.voiced <= tok.voiced;
      f1.neg    <= quad[1];
      f1.last   <= tok.last;
      f1.eos    <= tok.eos;

      xn2 <= xn1;
      x22 <= x21;
      t12 <= COEF_B - p2[27:15];
      f2  <= f1;

      xn3 <= xn2;
      t23 <= COEF_A - p3[30:15];
      f3  <= f2;

      if (!f3.voiced) begin
        sample <= 16'sd0;
      end else if (f3.neg) begin
        sample <= -$signed(ys);
      end else begin
        sample <= $signed(ys);
      end
      last <= f3.last;
      eos  <= f3.eos;
    end
  end

endmodule

// ===== bench/upsampled_sine_source_test.sv =====
`timescale 1ns / 1ps
module upsampled_sine_source_test;
  import uss_pkg::*;

  localparam int ADDR_BITS     = 10;
  localparam int QUAD_BITS     = ADDR_BITS - 2;
  localparam int MAX_SPF       = 64;
  localparam int IDLE_PCT      = 17;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RAND_PHASES   = 8;
  localparam int RAND_FRAMES   = 36;

  // polynomial coefficients of the quarter-wave sine
  localparam longint unsigned POLY_A = 51466;
  localparam longint unsigned POLY_B = 21077;
  localparam longint unsigned POLY_C = 2383;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               eos;
  } sample_exp_t;

  typedef enum logic [0:0] {ROW_FRAME, ROW_CONFIG} row_kind_t;

  // frame rows: word0 = pitch, word1 unused
  // config rows: word0 = samples_per_frame data, word1 = step_scale data
  typedef struct packed {
    row_kind_t          kind;
    logic [23:0]        word0;
    logic [23:0]        word1;
    logic               fin;
    logic               typed;
    logic signed [15:0] want;
  } plan_row_t;

  logic clk;
  logic rst;

  uss_cfg_if    cfg_ch ();
  uss_pitch_if  pitch_ch ();
  uss_sample_if sample_ch ();

  upsampled_sine_source dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pitch   (pitch_ch),
    .samples (sample_ch)
  );

  // oscillator shadow state
  logic [6:0]  model_spf;
  logic [23:0] model_step;
  logic [31:0] model_phase;

  sample_exp_t pending_samples[$];

  int errors;
  int frames_sent;
  int samples_checked;
  int reg_writes;
  int cycle_count;
  bit no_idle;
  bit hold_request;

  plan_row_t plan [24];

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples pending", cycle_count,
               pending_samples.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at sample %0d: %s got %0d want %0d", samples_checked, what, got,
             want);
    errors++;
  endtask

  // sine of a turn-based phase, Q1.15
  function automatic logic signed [15:0] sine_q15_of(input logic [31:0] ph);
    logic [ADDR_BITS-1:0] addr;
    logic [1:0]           quad;
    longint unsigned      r, x, xn, x2, t1, t2, y;
    addr = ph[31 -: ADDR_BITS];
    quad = addr[ADDR_BITS-1 -: 2];
    r    = addr[QUAD_BITS-1:0];
    x    = quad[0] ? ((longint'(1) << QUAD_BITS) - r) : r;
    xn   = x << (15 - QUAD_BITS);
    x2   = (xn * xn) >> 15;
    t1   = POLY_B - ((x2 * POLY_C) >> 15);
    t2   = POLY_A - ((x2 * t1) >> 15);
    y    = (xn * t2) >> 15;
    if (y > 32767) y = 32767;
    return quad[1] ? -$signed(y[15:0]) : $signed(y[15:0]);
  endfunction

  // queue the samples one pitch frame produces and advance the shadow phase
  function automatic void predict_frame(input logic [15:0] hz, input logic fin,
                                        input logic typed,
                                        input logic signed [15:0] typed_val);
    int unsigned n;
    int unsigned k;
    logic [40:0] inc;
    sample_exp_t s;
    n = (model_spf == 0) ? 1 : ((model_spf > MAX_SPF) ? MAX_SPF : model_spf);
    inc = ({25'd0, hz} * {17'd0, model_step} + 41'd8) >> 4;
    for (k = 0; k < n; k++) begin
      s.sample = 16'sd0;
      if (hz != 0) begin
        model_phase = model_phase + inc[31:0];
        s.sample = sine_q15_of(model_phase);
      end
      if (typed) s.sample = typed_val;
      s.last = (k == n - 1);
      s.eos  = s.last && fin;
      pending_samples.push_back(s);
    end
    if (fin) model_phase = '0;
  endfunction

  // offer one pitch request, idling at random first
  task automatic send_frame(input logic [15:0] hz, input logic fin, input logic typed,
                            input logic signed [15:0] typed_val);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      pitch_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pitch_ch.valid       <= 1'b1;
    pitch_ch.pitch_hz    <= hz;
    pitch_ch.final_frame <= fin;
    @(posedge clk);
    while (!pitch_ch.ready) @(posedge clk);
    predict_frame(hz, fin, typed, typed_val);
    frames_sent++;
  endtask

  // wait until every queued sample has come out and the pipeline is empty
  task automatic drain();
    pitch_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_SAMPLES_PER_FRAME) model_spf = val[6:0];
    else model_step = val;
    reg_writes++;
  endtask

  task automatic set_config(input logic [23:0] spf_data, input logic [23:0] step_data);
    write_reg(CFG_SAMPLES_PER_FRAME, spf_data);
    write_reg(CFG_STEP_SCALE, step_data);
    cfg_ch.valid <= 1'b0;
  endtask

  // sample sink: checks each accepted sample and drives ready
  initial begin : sample_sink
    sample_exp_t want;
    int hold_left;
    hold_left = 0;
    sample_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && sample_ch.valid && sample_ch.ready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("unexpected sample", sample_ch.sample, 0);
        end else begin
          want = pending_samples.pop_front();
          if (sample_ch.sample !== want.sample)
            report_mismatch("sample", sample_ch.sample, want.sample);
          if (sample_ch.last_of_frame !== want.last)
            report_mismatch("last_of_frame", sample_ch.last_of_frame, want.last);
          if (sample_ch.end_of_signal !== want.eos)
            report_mismatch("end_of_signal", sample_ch.end_of_signal, want.eos);
        end
        samples_checked++;
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        sample_ch.ready <= 1'b0;
      end else begin
        sample_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // main sequence
  initial begin : pitch_source
    int r;
    int ph;
    int i;
    int pick;
    logic [6:0]  spf_val;
    logic [23:0] spf_data;
    logic [23:0] step_data;
    logic [15:0] hz;
    logic        fin;

    errors = 0;
    frames_sent = 0;
    samples_checked = 0;
    reg_writes = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    model_spf = 7'd10;
    model_step = 24'd178957;
    model_phase = '0;

    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SAMPLES_PER_FRAME;
    cfg_ch.data = '0;
    pitch_ch.valid = 1'b0;
    pitch_ch.pitch_hz = '0;
    pitch_ch.final_frame = 1'b0;

    // quarter-turn steps: step 2^22 at 256 Hz advances exactly 2^30 per sample
    plan = '{
      '{ROW_FRAME,  24'd0,        24'd0,        1'b0, 1'b1, 16'sd0},
      '{ROW_FRAME,  24'd7040,     24'd0,        1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd65535,    24'd0,        1'b1, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd1,        24'd0,        1'b1, 1'b0, 16'sd0},
      '{ROW_CONFIG, 24'd1,        24'd4194304,  1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd4096,     24'd0,        1'b0, 1'b1, 16'sd32767},
      '{ROW_FRAME,  24'd4096,     24'd0,        1'b0, 1'b1, 16'sd0},
      '{ROW_FRAME,  24'd4096,     24'd0,        1'b0, 1'b1, -16'sd32767},
      '{ROW_FRAME,  24'd4096,     24'd0,        1'b0, 1'b1, 16'sd0},
      '{ROW_FRAME,  24'd4096,     24'd0,        1'b1, 1'b1, 16'sd32767},
      '{ROW_FRAME,  24'd4096,     24'd0,        1'b0, 1'b1, 16'sd32767},
      '{ROW_CONFIG, 24'd0,        24'd16777215, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd65535,    24'd0,        1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd1,        24'd0,        1'b1, 1'b0, 16'sd0},
      '{ROW_CONFIG, 24'd100,      24'd0,        1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd4096,     24'd0,        1'b0, 1'b1, 16'sd0},
      '{ROW_FRAME,  24'd0,        24'd0,        1'b1, 1'b1, 16'sd0},
      '{ROW_CONFIG, 24'hABCD85,   24'd1,        1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd65535,    24'd0,        1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd32768,    24'd0,        1'b1, 1'b0, 16'sd0},
      '{ROW_CONFIG, 24'd64,       24'd178957,   1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd7040,     24'd0,        1'b0, 1'b0, 16'sd0},
      '{ROW_CONFIG, 24'd127,      24'd12345,    1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME,  24'd12345,    24'd0,        1'b1, 1'b0, 16'sd0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, reset defaults first
    for (r = 0; r < 24; r++) begin
      if (plan[r].kind == ROW_CONFIG) begin
        drain();
        set_config(plan[r].word0, plan[r].word1);
      end else begin
        send_frame(plan[r].word0[15:0], plan[r].fin, plan[r].typed, plan[r].want);
      end
    end

    // random phases, each with its own register setting
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      no_idle = (ph == 2);
      pick = $urandom_range(99);
      if (pick < 60) spf_val = 7'($urandom_range(1, 8));
      else if (pick < 75) spf_val = 7'($urandom_range(9, 20));
      else if (pick < 85) spf_val = 7'd64;
      else if (pick < 92) spf_val = 7'd0;
      else spf_val = 7'($urandom_range(65, 127));
      spf_data = {17'($urandom_range(0, 131071)), spf_val};
      if (pick < 75) spf_data[23:7] = '0;
      pick = $urandom_range(99);
      if (pick < 20) step_data = 24'd178957;
      else if (pick < 25) step_data = 24'd0;
      else if (pick < 30) step_data = 24'hFFFFFF;
      else step_data = 24'($urandom());
      set_config(spf_data, step_data);

      for (i = 0; i < RAND_FRAMES; i++) begin
        // long output stall while requests keep coming
        if (ph == 5 && i == 4) hold_request = 1'b1;
        // sender pause until the pipeline is empty
        if (ph == 6 && i == 18) drain();
        pick = $urandom_range(99);
        if (pick < 15) hz = 16'd0;
        else if (pick < 25) hz = 16'($urandom_range(1, 255));
        else if (pick < 35) hz = 16'($urandom_range(65280, 65535));
        else hz = 16'($urandom());
        fin = ($urandom_range(99) < 10);
        send_frame(hz, fin, 1'b0, 16'sd0);
      end
    end
    no_idle = 1'b0;
    drain();

    if (pending_samples.size() != 0) begin
      $display("%0d expected samples never arrived", pending_samples.size());
      errors++;
    end

    $display("ran %0d pitch frames (24 directed rows, %0d random phases) over %0d cycles",
             frames_sent, RAND_PHASES, cycle_count);
    $display("checked %0d samples across %0d register writes, %0d mismatches",
             samples_checked, reg_writes, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
